>>> design/pidc_pkg.sv
`timescale 1ns / 1ps
package pidc_pkg;

    // field and datapath widths
    localparam int unsigned ErrW   = 24;
    localparam int unsigned DtW    = 24;
    localparam int unsigned GainW  = 32;
    localparam int unsigned IntegW = 48;
    localparam int unsigned LpW    = 33;   // low-pass state never leaves the error range
    localparam int unsigned DriveW = 40;
    localparam int unsigned MulAW  = 34;   // signed multiplier operand a
    localparam int unsigned MulBW  = 25;   // signed multiplier operand b
    localparam int unsigned ProdW  = 59;   // kept product bits
    localparam int unsigned AddrW  = 4;

    // reset values of the state and the gain registers
    localparam logic [GainW-1:0]         KpReset = 32'd5242880;
    localparam logic [GainW-1:0]         KiReset = 32'd1048576000;
    localparam logic [GainW-1:0]         KdReset = 32'd10486;
    localparam logic signed [LpW-1:0]    LpReset = 33'sd1677722;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_KP = 2'd0,
        REG_KI = 2'd1,
        REG_KD = 2'd2
    } reg_idx_t;

    // sequencer steps, one multiply launched in each working step
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC,
        ST_LP,
        ST_PROP,
        ST_IHI,
        ST_ILO,
        ST_DHI,
        ST_DLO,
        ST_DONE
    } st_t;

    typedef struct packed {
        st_t  st;
        logic mul_en;
        logic finish;
    } ctrl_t;

endpackage

>>> design/pidc_mult.sv
`timescale 1ns / 1ps
module pidc_mult (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [pidc_pkg::MulAW-1:0]    a,
    input  logic signed [pidc_pkg::MulBW-1:0]    b,
    output logic signed [pidc_pkg::ProdW-1:0]    prod
);

    logic signed [pidc_pkg::MulAW+pidc_pkg::MulBW-1:0] full;
    logic signed [pidc_pkg::ProdW-1:0]                 prod_reg;

    assign full = a * b;

    // operand ranges keep every product inside the kept bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= full[pidc_pkg::ProdW-1:0];
        end
    end

    assign prod = prod_reg;

endmodule

>>> design/pidc_seq.sv
`timescale 1ns / 1ps
module pidc_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            out_busy,
    output logic            in_stall,
    output pidc_pkg::ctrl_t ctrl
);

    pidc_pkg::st_t st_reg;
    pidc_pkg::st_t st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= pidc_pkg::ST_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_comb
    begin
        st_next     = st_reg;
        ctrl.st     = st_reg;
        ctrl.mul_en = 1'b1;
        ctrl.finish = 1'b0;
        unique case (st_reg)
            pidc_pkg::ST_IDLE:
            begin
                ctrl.mul_en = 1'b0;
                if (in_valid)
                begin
                    st_next = pidc_pkg::ST_INC;
                end
            end
            pidc_pkg::ST_INC:  st_next = pidc_pkg::ST_LP;
            pidc_pkg::ST_LP:   st_next = pidc_pkg::ST_PROP;
            pidc_pkg::ST_PROP: st_next = pidc_pkg::ST_IHI;
            pidc_pkg::ST_IHI:  st_next = pidc_pkg::ST_ILO;
            pidc_pkg::ST_ILO:  st_next = pidc_pkg::ST_DHI;
            pidc_pkg::ST_DHI:  st_next = pidc_pkg::ST_DLO;
            pidc_pkg::ST_DLO:  st_next = pidc_pkg::ST_DONE;
            pidc_pkg::ST_DONE:
            begin
                ctrl.mul_en = 1'b0;
                // wait here while the previous result is still held
                if (!out_busy)
                begin
                    ctrl.finish = 1'b1;
                    st_next     = pidc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                ctrl.mul_en = 1'b0;
                st_next     = pidc_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall = (st_reg != pidc_pkg::ST_IDLE);

endmodule

>>> design/pid_controller_step.sv
`timescale 1ns / 1ps
// pid controller step with a low-pass filtered derivative, fixed point
// input channel: in_valid / in_stall carry error_value (signed q8.16) and
//   step_time (unsigned q0.24); an item is taken when in_valid is high and
//   in_stall is low
// output channel: out_valid / out_stall carry drive_value (signed q24.16)
//   and drive_clipped, set when the drive hit the 40-bit limits
// gains kp, ki, kd (unsigned q12.20) sit on the apb port at 0x0, 0x4, 0x8;
//   pready is always high, writes to 0xc to 0xf are dropped; paddr[1:0] is ignored
// from acceptance to a valid result, the shared 34x25 multiplier is used
//   once per step for error*dt, dt*(error-x), kp*|error| and two half
//   products for each of ki*|i| and kd*|d|
// in_stall stays high for the whole sequence, so the next item waits for it;
//   a new item may be taken while the last result is still held
// if out_stall holds the previous result when the next one is done, the
//   sequencer waits in its final step until the output register frees up
// reset clears the integral, sets the filter state to 0.1 and loads the
//   default gains kp 5.0, ki 1000.0, kd about 0.01
module pid_controller_step (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pidc_pkg::AddrW-1:0]         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [pidc_pkg::ErrW-1:0]   error_value,
    input  logic [pidc_pkg::DtW-1:0]           step_time,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [pidc_pkg::DriveW-1:0] drive_value,
    output logic                               drive_clipped
);

    // configuration registers
    logic [pidc_pkg::GainW-1:0] kp_reg;
    logic [pidc_pkg::GainW-1:0] ki_reg;
    logic [pidc_pkg::GainW-1:0] kd_reg;
    logic                       cfg_wr;
    pidc_pkg::reg_idx_t         cfg_idx;

    // item and state registers
    logic signed [pidc_pkg::ErrW-1:0]   err_reg;
    logic [pidc_pkg::DtW-1:0]           dt_reg;
    logic signed [pidc_pkg::IntegW-1:0] integ_reg;
    logic signed [pidc_pkg::IntegW-1:0] integ_next;
    logic signed [pidc_pkg::LpW-1:0]    lp_reg;
    logic signed [pidc_pkg::LpW-1:0]    lp_next;
    logic [55:0]                        acc_reg;
    logic signed [36:0]                 pterm_reg;
    logic signed [36:0]                 pterm_next;
    logic signed [55:0]                 sum_reg;
    logic signed [55:0]                 sum_next;
    logic                               out_valid_reg;
    logic signed [pidc_pkg::DriveW-1:0] drive_reg;
    logic signed [pidc_pkg::DriveW-1:0] drive_next;
    logic                               clip_reg;
    logic                               clip_next;

    // sequencer and multiplier
    pidc_pkg::ctrl_t                    ctrl;
    logic                               in_take;
    logic                               out_busy;
    logic signed [pidc_pkg::MulAW-1:0]  mul_a;
    logic signed [pidc_pkg::MulBW-1:0]  mul_b;
    logic signed [pidc_pkg::ProdW-1:0]  prod;

    // datapath intermediates
    logic signed [31:0]  e24;
    logic signed [33:0]  diff;
    logic [23:0]         err_mag;
    logic [47:0]         integ_mag;
    logic [32:0]         diff_mag;
    logic signed [48:0]  inc_round;
    logic signed [48:0]  inc_shift;
    logic signed [48:0]  integ_sum;
    logic signed [58:0]  lp_round;
    logic signed [58:0]  lp_shift;
    logic [56:0]         prop_round;
    logic [56:0]         gain_acc;
    logic [57:0]         gain_round;
    logic [52:0]         term_mag;
    logic                term_neg;
    logic signed [53:0]  term;
    logic signed [55:0]  sum_final;

    // ---------------------------------------------------------------
    // apb configuration port
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = pidc_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= pidc_pkg::KpReset;
            ki_reg <= pidc_pkg::KiReset;
            kd_reg <= pidc_pkg::KdReset;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                pidc_pkg::REG_KP: kp_reg <= pwdata;
                pidc_pkg::REG_KI: ki_reg <= pwdata;
                pidc_pkg::REG_KD: kd_reg <= pwdata;
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            pidc_pkg::REG_KP: prdata = kp_reg;
            pidc_pkg::REG_KI: prdata = ki_reg;
            pidc_pkg::REG_KD: prdata = kd_reg;
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer and shared multiplier
    // ---------------------------------------------------------------
    assign out_busy = out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    pidc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    pidc_mult u_mult (
        .clk  (clk),
        .en   (ctrl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // ---------------------------------------------------------------
    // operand forming
    // ---------------------------------------------------------------
    assign e24      = {err_reg, 8'd0};
    // x follows the error from its side, so x and error-x stay narrow
    assign diff     = {{2{e24[31]}}, e24} - {lp_reg[32], lp_reg};
    assign err_mag  = err_reg[23] ? 24'(-err_reg) : 24'(err_reg);
    assign integ_mag = integ_reg[47] ? 48'(-integ_reg) : 48'(integ_reg);
    assign diff_mag = diff[33] ? 33'(-diff) : diff[32:0];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.st)
            pidc_pkg::ST_INC:
            begin
                mul_a = {{10{err_reg[23]}}, err_reg};
                mul_b = {1'b0, dt_reg};
            end
            pidc_pkg::ST_LP:
            begin
                mul_a = diff;
                mul_b = {1'b0, dt_reg};
            end
            pidc_pkg::ST_PROP:
            begin
                mul_a = {2'b00, kp_reg};
                mul_b = {1'b0, err_mag};
            end
            pidc_pkg::ST_IHI:
            begin
                mul_a = {2'b00, ki_reg};
                mul_b = {1'b0, integ_mag[47:24]};
            end
            pidc_pkg::ST_ILO:
            begin
                mul_a = {2'b00, ki_reg};
                mul_b = {1'b0, integ_mag[23:0]};
            end
            pidc_pkg::ST_DHI:
            begin
                mul_a = {2'b00, kd_reg};
                mul_b = {16'd0, diff_mag[32:24]};
            end
            pidc_pkg::ST_DLO:
            begin
                mul_a = {2'b00, kd_reg};
                mul_b = {1'b0, diff_mag[23:0]};
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // consuming the registered product
    // ---------------------------------------------------------------

    // integral: q8.40 rounded to q24.24, saturating accumulate
    assign inc_round = prod[48:0] + 49'sd32768;
    assign inc_shift = inc_round >>> 16;
    assign integ_sum = {integ_reg[47], integ_reg} + inc_shift;

    always_comb
    begin
        if (integ_sum[48] != integ_sum[47])
        begin
            integ_next = integ_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            integ_next = integ_sum[47:0];
        end
    end

    // filter: x += round(dt * (e - x)), never overshoots the error
    assign lp_round = prod + 59'sd8388608;
    assign lp_shift = lp_round >>> 24;
    assign lp_next  = lp_reg + lp_shift[32:0];

    // proportional term, rounded on the magnitude
    assign prop_round = {1'b0, prod[55:0]} + 57'd524288;
    assign pterm_next = err_reg[23] ? -$signed({1'b0, prop_round[55:20]})
                                    :  $signed({1'b0, prop_round[55:20]});

    // gain term: high half product plus the low half shifted down 24
    assign gain_acc   = {1'b0, acc_reg} + {25'd0, prod[55:24]};
    assign gain_round = {1'b0, gain_acc} + 58'd8;
    assign term_mag   = gain_round[56:4];
    assign term_neg   = (ctrl.st == pidc_pkg::ST_DHI) ? integ_reg[47] : diff[33];
    assign term       = term_neg ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});

    assign sum_next  = {{19{pterm_reg[36]}}, pterm_reg} + {{2{term[53]}}, term};
    assign sum_final = sum_reg + {{2{term[53]}}, term};

    // output clamp to the signed 40-bit range
    always_comb
    begin
        clip_next = !((&sum_final[55:39]) || !(|sum_final[55:39]));
        if (clip_next)
        begin
            drive_next = sum_final[55] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end
        else
        begin
            drive_next = sum_final[39:0];
        end
    end

    // item capture and working registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            err_reg <= error_value;
            dt_reg  <= step_time;
        end
        if (ctrl.st == pidc_pkg::ST_IHI)
        begin
            pterm_reg <= pterm_next;
        end
        if (ctrl.st == pidc_pkg::ST_ILO || ctrl.st == pidc_pkg::ST_DLO)
        begin
            acc_reg <= prod[55:0];
        end
        if (ctrl.st == pidc_pkg::ST_DHI)
        begin
            sum_reg <= sum_next;
        end
        if (ctrl.finish)
        begin
            drive_reg <= drive_next;
            clip_reg  <= clip_next;
        end
    end

    // controller state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg     <= '0;
            lp_reg        <= pidc_pkg::LpReset;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.st == pidc_pkg::ST_LP)
            begin
                integ_reg <= integ_next;
            end
            if (ctrl.st == pidc_pkg::ST_PROP)
            begin
                lp_reg <= lp_next;
            end
            if (ctrl.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_value   = drive_reg;
    assign drive_clipped = clip_reg;

endmodule

>>> test/pid_controller_step_test.sv
`timescale 1ns / 1ps
module pid_controller_step_test;

    // clock, reset and run length
    localparam int  ResetCycles  = 12;
    localparam int  SettleCycles = 16;     // longer than one item takes through the block
    localparam int  CycleLimit   = 200000;
    localparam int  MaxReports   = 10;

    // random part: batches of items, one gain setting per batch
    localparam int  NumBatches   = 16;
    localparam int  BatchItems   = 87;
    localparam int  WindupItems  = 40;
    localparam int  WindupHold   = 40;
    localparam int  UnwindItems  = 60;

    // controller constants, own copy of the reset state
    localparam logic [31:0] KpDefault = 32'd5242880;      // 5.0
    localparam logic [31:0] KiDefault = 32'd1048576000;   // 1000.0
    localparam logic [31:0] KdDefault = 32'd10486;        // about 0.01
    localparam longint      LpDefault = 64'sd1677722;     // 0.1 in q16.24

    localparam longint IntegMax = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint IntegMin = -IntegMax - 1;
    localparam longint LpMax    = 64'sh0000_007F_FFFF_FFFF;
    localparam longint LpMin    = -LpMax - 1;
    localparam longint DriveMax = 64'sh0000_007F_FFFF_FFFF;
    localparam longint DriveMin = -DriveMax - 1;
    localparam longint Mask24   = 64'sh0000_0000_00FF_FFFF;

    // field extremes, kept 32 bits wide for the stimulus table (40 for drive)
    localparam logic [31:0] Zero32 = 32'h0000_0000;
    localparam logic [31:0] Max32  = 32'hFFFF_FFFF;
    localparam logic [31:0] ErrMax = 32'h007F_FFFF;
    localparam logic [31:0] ErrMin = 32'h0080_0000;
    localparam logic [31:0] ErrNeg1 = 32'h00FF_FFFF;
    localparam logic [31:0] DtMax  = 32'h00FF_FFFF;
    localparam logic [39:0] Zero40 = 40'h0;

    // register index with no register behind it
    localparam logic [1:0] RegUnused = 2'd3;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_GAINS,
        ROW_BADREG
    } row_kind_t;

    typedef enum logic [1:0] {
        BIAS_NONE,
        BIAS_POS,
        BIAS_NEG
    } bias_t;

    // one row of the directed table: an item (a = error, b = dt) with an
    // optional fixed expectation, a gain setting (a, b, c = kp, ki, kd) or a
    // write to the unused register address (a = data)
    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic        typed;
        logic [39:0] drive;
        logic        clip;
    } dir_row_t;

    typedef struct {
        logic signed [39:0] drive;
        logic               clipped;
    } drive_res_t;

    localparam int NumDirRows = 24;

    dir_row_t dir_rows [NumDirRows] = '{
        // default gains, from the reset state
        '{ROW_ITEM,   Zero32,        Zero32,        Zero32, 1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   ErrMax,        DtMax,         Zero32, 1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   ErrMin,        DtMax,         Zero32, 1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   ErrMin,        Zero32,        Zero32, 1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   ErrNeg1,       32'h1,         Zero32, 1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   32'h1,         32'h0080_0000, Zero32, 1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   ErrMax,        Zero32,        Zero32, 1'b0, Zero40, 1'b0},
        // write to an address with no register, must change nothing
        '{ROW_BADREG, Max32,         Zero32,        Zero32, 1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   32'h0012_3456, 32'h0065_4321, Zero32, 1'b0, Zero40, 1'b0},
        // all gains zero: drive is zero whatever the state
        '{ROW_GAINS,  Zero32,        Zero32,        Zero32, 1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   ErrMax,        DtMax,         Zero32, 1'b1, Zero40, 1'b0},
        '{ROW_ITEM,   ErrMin,        DtMax,         Zero32, 1'b1, Zero40, 1'b0},
        '{ROW_ITEM,   32'h005A_5A5A, 32'h00A5_A5A5, Zero32, 1'b1, Zero40, 1'b0},
        // all gains at full scale
        '{ROW_GAINS,  Max32,         Max32,         Max32,  1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   ErrMax,        DtMax,         Zero32, 1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   ErrMin,        DtMax,         Zero32, 1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   ErrMax,        32'h1,         Zero32, 1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   ErrMin,        Zero32,        Zero32, 1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   ErrNeg1,       DtMax,         Zero32, 1'b0, Zero40, 1'b0},
        // proportional path alone
        '{ROW_GAINS,  Max32,         Zero32,        Zero32, 1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   ErrMin,        Zero32,        Zero32, 1'b0, Zero40, 1'b0},
        // back to the default gains
        '{ROW_GAINS,  KpDefault,     KiDefault,     KdDefault, 1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   Zero32,        DtMax,         Zero32, 1'b0, Zero40, 1'b0},
        '{ROW_ITEM,   32'h1,         32'h1,         Zero32, 1'b0, Zero40, 1'b0}
    };

    // block ports, all inputs known from time zero
    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [pidc_pkg::AddrW-1:0]          paddr = '0;
    logic [31:0]                         pwdata = '0;
    logic [31:0]                         prdata;
    logic                                pready;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic signed [pidc_pkg::ErrW-1:0]    error_value = '0;
    logic [pidc_pkg::DtW-1:0]            step_time = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [pidc_pkg::DriveW-1:0]  drive_value;
    logic                                drive_clipped;

    // controller copy: gains, integral and low-pass state
    logic [31:0] gain_reg [3];
    longint      integ_acc;
    longint      lp_state;

    drive_res_t  drive_expect_q [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    pid_controller_step dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .error_value   (error_value),
        .step_time     (step_time),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .drive_value   (drive_value),
        .drive_clipped (drive_clipped)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CycleLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint want_v,
                                   input longint got_v);
        mismatch_count++;
        if (mismatch_count <= MaxReports)
            $display("mismatch: %s expected %0d got %0d", what, want_v, got_v);
    endtask

    function automatic longint clip_range(input longint v, input longint lo,
                                          input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // gain (q12.20) times v, scaled down by 2^28 and rounded half away from
    // zero on the magnitude; the product is split to stay inside 64 bits
    function automatic longint scaled_gain(input logic [31:0] g, input longint v);
        longint gl;
        longint m;
        longint a;
        longint r;
        gl = longint'({32'd0, g});
        m = (v < 0) ? -v : v;
        a = gl * (m >>> 24) + ((gl * (m & Mask24)) >>> 24);
        r = (a + 8) >>> 4;
        return (v < 0) ? -r : r;
    endfunction

    // one controller step: updates the integral and the filter state and
    // returns the saturated drive with its clip flag
    function automatic drive_res_t compute_drive(input logic signed [23:0] err_in,
                                                 input logic [23:0] dt_in);
        longint     err;
        longint     dt;
        longint     inc;
        longint     e24;
        longint     stepv;
        longint     deriv;
        longint     pterm;
        longint     total;
        longint     sat;
        drive_res_t res;
        err = err_in;
        dt = dt_in;

        // integral: q8.40 product rounded to q24.24, saturating sum
        inc = (err * dt + 32768) >>> 16;
        integ_acc = clip_range(integ_acc + inc, IntegMin, IntegMax);

        // low-pass state moves toward the error by dt of the gap
        e24 = err * 256;
        stepv = (dt * (e24 - lp_state) + 8388608) >>> 24;
        lp_state = clip_range(lp_state + stepv, LpMin, LpMax);
        deriv = e24 - lp_state;

        // proportional term rounded from q.36 on the magnitude
        pterm = (((err < 0) ? -err : err)
                 * longint'({32'd0, gain_reg[pidc_pkg::REG_KP]}) + 524288) >>> 20;
        if (err < 0)
            pterm = -pterm;

        total = pterm + scaled_gain(gain_reg[pidc_pkg::REG_KI], integ_acc)
                + scaled_gain(gain_reg[pidc_pkg::REG_KD], deriv);
        sat = clip_range(total, DriveMin, DriveMax);
        res.drive = sat;
        res.clipped = (sat != total);
        return res;
    endfunction

    // apb transfers; psel drops after each so that transfers never run back to back
    task automatic apb_write(input logic [pidc_pkg::AddrW-1:0] addr,
                             input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [pidc_pkg::AddrW-1:0] addr,
                            output logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write one gain, keep the copy in step and read it back
    task automatic write_gain(input pidc_pkg::reg_idx_t idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_write({idx, 2'b00}, value);
        gain_reg[idx] = value;
        apb_read({idx, 2'b00}, rd);
        if (rd !== value)
            report_mismatch("gain register readback", value, rd);
    endtask

    task automatic set_gains(input logic [31:0] kp, input logic [31:0] ki,
                             input logic [31:0] kd);
        write_gain(pidc_pkg::REG_KP, kp);
        write_gain(pidc_pkg::REG_KI, ki);
        write_gain(pidc_pkg::REG_KD, kd);
    endtask

    // drop valid, wait until every expected drive item has come out, then settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (drive_expect_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // offer one item, predict its drive once it is taken; valid stays high
    // after acceptance so the next item can follow without a gap
    task automatic send_item(input logic [23:0] err, input logic [23:0] dt,
                             input logic typed = 1'b0,
                             input logic [39:0] t_drive = '0,
                             input logic t_clip = 1'b0);
        drive_res_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        error_value <= err;
        step_time <= dt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = compute_drive(err, dt);
        if (typed)
        begin
            res.drive = t_drive;
            res.clipped = t_clip;
        end
        drive_expect_q.push_back(res);
    endtask

    // zero, full scale, fractional and mid-range gains
    function automatic logic [31:0] pick_gain();
        case ($urandom_range(5))
            0: return Zero32;
            1: return Max32;
            2: return $urandom & 32'h000F_FFFF;
            3: return $urandom & 32'h00FF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // random items; a biased burst keeps most large errors on one side so
    // the integral builds up and the drive reaches its limits
    task automatic send_random_burst(input int count, input bias_t bias);
        logic [31:0] raw;
        logic [31:0] raw_dt;
        logic [23:0] err;
        logic [23:0] dt;
        repeat (count)
        begin
            raw = $urandom;
            raw_dt = $urandom;
            case ($urandom_range(9))
                0: err = ErrMax[23:0];
                1: err = ErrMin[23:0];
                2: err = '0;
                3: err = {{15{raw[8]}}, raw[8:0]};
                4, 5, 6:
                begin
                    if (bias == BIAS_POS)
                        err = {1'b0, raw[22:0]};
                    else if (bias == BIAS_NEG)
                        err = {1'b1, raw[22:0]};
                    else
                        err = raw[23:0];
                end
                default: err = raw[23:0];
            endcase
            case ($urandom_range(5))
                0: dt = '0;
                1: dt = DtMax[23:0];
                2: dt = {12'd0, raw_dt[11:0]};
                default: dt = raw_dt[23:0];
            endcase
            send_item(err, dt);
        end
    endtask

    // result side: random stall, every accepted item checked in order
    always @(posedge clk)
    begin : drive_monitor
        drive_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_expect_q.size() == 0)
                report_mismatch("drive item with nothing pending", 0, drive_value);
            else
            begin
                want = drive_expect_q.pop_front();
                if (drive_value !== want.drive)
                    report_mismatch("drive_value", want.drive, drive_value);
                if (drive_clipped !== want.clipped)
                    report_mismatch("drive_clipped", want.clipped, drive_clipped);
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    initial
    begin
        logic [31:0] raw;

        gain_reg[pidc_pkg::REG_KP] = KpDefault;
        gain_reg[pidc_pkg::REG_KI] = KiDefault;
        gain_reg[pidc_pkg::REG_KD] = KdDefault;
        integ_acc = 0;
        lp_state = LpDefault;
        send_idle_pct = 31;
        recv_idle_pct = 53;

        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, gain changes only once the block is drained
        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                ROW_ITEM:
                begin
                    send_item(dir_rows[i].a[23:0], dir_rows[i].b[23:0],
                              dir_rows[i].typed, dir_rows[i].drive, dir_rows[i].clip);
                end
                ROW_GAINS:
                begin
                    wait_drained();
                    set_gains(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c);
                end
                default:
                begin
                    wait_drained();
                    apb_write({RegUnused, 2'b00}, dir_rows[i].a);
                end
            endcase
        end

        // random batches: receiver-heavy idling, then sender-heavy, then none
        for (int b = 0; b < NumBatches; b++)
        begin
            if (b < NumBatches / 3)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 53;
            end
            else if (b < 2 * NumBatches / 3)
            begin
                send_idle_pct = 53;
                recv_idle_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_drained();
            set_gains(pick_gain(), pick_gain(), pick_gain());
            send_random_burst(BatchItems, bias_t'($urandom_range(2)));
        end

        // build the integral up with near full-scale items, full ki
        // drives the output into its clip from there on
        wait_drained();
        set_gains(pick_gain(), Max32, pick_gain());
        repeat (WindupItems)
        begin
            raw = $urandom;
            send_item({1'b0, 13'h1FFF, raw[9:0]}, {14'h3FFF, raw[19:10]});
        end
        repeat (WindupHold) send_item(ErrMax[23:0], DtMax[23:0]);

        // pull it back down with negative errors and new gains
        wait_drained();
        set_gains(pick_gain(), pick_gain(), pick_gain());
        send_random_burst(UnwindItems, BIAS_NEG);

        wait_drained();
        if (mismatch_count == 0 && drive_expect_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
design/pidc_pkg.sv
design/pidc_mult.sv
design/pidc_seq.sv
design/pid_controller_step.sv
test/pid_controller_step_test.sv
